### rtl/hsb_pkg.sv
`default_nettype none

package hsb_pkg;

    localparam int SIZEW = 9;
    localparam int POSW  = 16;
    localparam int HW    = 24;
    localparam int RADW  = 17;
    localparam int CNTW  = 17;

    localparam int H_MAX = 8388607;
    localparam int H_MIN = -8388608;

    localparam logic [SIZEW-1:0] SIZE_RESET = 9'd64;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_BRUSH = 2'd2;

    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic REG_GRID_DEPTH = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_QRD,
        ST_QMUL,
        ST_QSUM,
        ST_BRUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic load_wr;
        logic q_rd;
        logic q_mul;
        logic q_sum;
        logic b_run;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic q_rd_last;
        logic b_done;
    } t_status;

endpackage

`default_nettype wire

### rtl/hsb_ctrl.sv
`default_nettype none

module hsb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_in_mode,
    input  wire logic             i_out_stall,
    input  wire hsb_pkg::t_status i_status,
    output hsb_pkg::t_cmd         o_cmd,
    output logic                  o_in_stall,
    output logic                  o_out_valid
);
    import hsb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (i_status.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_mode)
                        MODE_LOAD:  n_state = ST_LOAD;
                        MODE_QUERY: n_state = ST_QRD;
                        MODE_BRUSH: n_state = ST_BRUSH;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_LOAD:  n_state = ST_DONE;
            ST_QRD:   if (i_status.q_rd_last) n_state = ST_QMUL;
            ST_QMUL:  n_state = ST_QSUM;
            ST_QSUM:  n_state = ST_DONE;
            ST_BRUSH: if (i_status.b_done) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE:  o_cmd.capture  = i_in_valid;
            ST_LOAD:  o_cmd.load_wr  = 1'b1;
            ST_QRD:   o_cmd.q_rd     = 1'b1;
            ST_QMUL:  o_cmd.q_mul    = 1'b1;
            ST_QSUM:  o_cmd.q_sum    = 1'b1;
            ST_BRUSH: o_cmd.b_run    = 1'b1;
            ST_DONE:  o_cmd.out_load = out_free;
            default:  o_cmd = '0;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/hsb_dp.sv
`default_nettype none

module hsb_dp #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire hsb_pkg::t_cmd                    i_cmd,
    input  wire logic [hsb_pkg::SIZEW-1:0]        i_grid_width,
    input  wire logic [hsb_pkg::SIZEW-1:0]        i_grid_depth,
    input  wire logic [1:0]                       i_mode,
    input  wire logic [7:0]                       i_vertex_col,
    input  wire logic [7:0]                       i_vertex_row,
    input  wire logic [hsb_pkg::POSW-1:0]         i_x_pos,
    input  wire logic [hsb_pkg::POSW-1:0]         i_z_pos,
    input  wire logic signed [hsb_pkg::HW-1:0]    i_y_pos,
    input  wire logic signed [hsb_pkg::HW-1:0]    i_value,
    input  wire logic [hsb_pkg::RADW-1:0]         i_radius,
    output hsb_pkg::t_status                      o_status,
    output logic signed [hsb_pkg::HW-1:0]         o_height,
    output logic [hsb_pkg::CNTW-1:0]              o_changed_count
);
    import hsb_pkg::*;

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = (SIZEW > $clog2(MAX_SIDE + 1)) ? SIZEW : $clog2(MAX_SIDE + 1);
    localparam int PW    = CW + 8;
    localparam int XW    = (PW > POSW) ? PW : POSW;
    localparam int DW    = (CW + 10 > 18) ? CW + 10 : 18;
    localparam int YW    = HW + 1;
    localparam int SQW   = ((2 * DW > 2 * YW) ? 2 * DW : 2 * YW) + 2;
    localparam int PRW   = HW + 11;
    localparam int ACW   = PRW + 2;

    function automatic logic [EW-1:0] eff_size(input logic [SIZEW-1:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        if (e < EW'(2)) begin
            e = EW'(2);
        end else if (e > EW'(MAX_SIDE)) begin
            e = EW'(MAX_SIDE);
        end
        return e;
    endfunction

    // captured request
    logic [1:0]             r_mode;
    logic [7:0]             r_col, r_row;
    logic [POSW-1:0]        r_xp, r_zp;
    logic signed [HW-1:0]   r_yp, r_val;
    logic [2*RADW-1:0]      r_r2;

    // height memory
    logic [HW-1:0]          mem [DEPTH];
    logic [HW-1:0]          r_rdata;
    logic                   we, re;
    logic [AW-1:0]          wa, ra;
    logic [HW-1:0]          wd;
    logic [AW-1:0]          r_clr;

    // grid geometry
    logic [EW-1:0]          w, d, wm1, dm1, wm2, dm2;
    logic [PW-1:0]          xmax, zmax, xc, zc;
    logic [CW-1:0]          c0, r0, cc, rc;
    logic [8:0]             fx, fz;
    logic                   upper;
    logic                   load_ok;

    // query
    logic [2:0]             r_qk;
    logic signed [HW-1:0]   r_h [4];
    logic [CW-1:0]          q_row, q_col;
    logic signed [YW-1:0]   d1, d2;
    logic signed [HW-1:0]   base;
    logic signed [9:0]      w1, w2;
    logic signed [PRW-1:0]  r_p1, r_p2;
    logic signed [HW-1:0]   r_base;
    logic signed [ACW-1:0]  acc, rnd;
    logic signed [HW-1:0]   r_res_h;

    // brush sweep
    logic [CW-1:0]          r_br, r_bc, r_r1, r_c1;
    logic                   r_issued, r_v1, r_v2;
    logic signed [DW-1:0]   dx, dz;
    logic signed [YW-1:0]   dy;
    logic [2*DW-1:0]        r_dx2, r_dz2;
    logic [2*YW-1:0]        r_dy2;
    logic signed [HW-1:0]   r_h2;
    logic [AW-1:0]          r_a2;
    logic [SQW-1:0]         dist2;
    logic                   sel;
    logic signed [YW-1:0]   hsum;
    logic signed [HW-1:0]   hnew;
    logic [CNTW-1:0]        r_cnt;
    logic                   issue;

    assign w   = eff_size(i_grid_width);
    assign d   = eff_size(i_grid_depth);
    assign wm1 = w - EW'(1);
    assign dm1 = d - EW'(1);
    assign wm2 = w - EW'(2);
    assign dm2 = d - EW'(2);

    assign xmax = {wm1[CW-1:0], 8'h00};
    assign zmax = {dm1[CW-1:0], 8'h00};
    assign xc   = (XW'(r_xp) > XW'(xmax)) ? xmax : PW'(r_xp);
    assign zc   = (XW'(r_zp) > XW'(zmax)) ? zmax : PW'(r_zp);
    assign c0   = xc[PW-1:8];
    assign r0   = zc[PW-1:8];
    // the last vertex line uses the last cell at a fraction of one
    assign cc   = (c0 > wm2[CW-1:0]) ? wm2[CW-1:0] : c0;
    assign rc   = (r0 > dm2[CW-1:0]) ? dm2[CW-1:0] : r0;
    assign fx   = 9'(xc - {cc, 8'h00});
    assign fz   = 9'(zc - {rc, 8'h00});
    assign upper = (10'(fx) + 10'(fz)) > 10'd256;

    assign load_ok = (EW'(r_col) < w) && (EW'(r_row) < d);

    // query corner order: (r,c) (r,c+1) (r+1,c) (r+1,c+1)
    assign q_row = rc + CW'(r_qk[1]);
    assign q_col = cc + CW'(r_qk[0]);

    assign issue = i_cmd.b_run && !r_issued;

    always_comb begin
        re = i_cmd.q_rd || issue;
        ra = i_cmd.q_rd ? {q_row, q_col} : {r_br, r_bc};
        we = 1'b0;
        wa = r_a2;
        wd = hnew;
        if (i_cmd.clr_step) begin
            we = 1'b1;
            wa = r_clr;
            wd = '0;
        end else if (i_cmd.load_wr) begin
            we = load_ok;
            wa = {CW'(r_row), CW'(r_col)};
            wd = r_val;
        end else if (i_cmd.b_run) begin
            we = r_v2 && sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rdata <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_col  <= i_vertex_col;
            r_row  <= i_vertex_row;
            r_xp   <= i_x_pos;
            r_zp   <= i_z_pos;
            r_yp   <= i_y_pos;
            r_val  <= i_value;
            r_r2   <= i_radius * i_radius;
        end
    end

    // query: four reads, then products, then round and saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qk <= '0;
        end else if (i_cmd.capture) begin
            r_qk <= '0;
        end else if (i_cmd.q_rd) begin
            r_qk <= r_qk + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_rd && (r_qk != 3'd0)) begin
            r_h[2'(r_qk - 3'd1)] <= r_rdata;
        end
    end

    always_comb begin
        if (upper) begin
            base = r_h[2];
            d1   = YW'(r_h[3]) - YW'(r_h[2]);
            d2   = YW'(r_h[1]) - YW'(r_h[3]);
            w2   = signed'(10'd256 - 10'(fz));
        end else begin
            base = r_h[0];
            d1   = YW'(r_h[1]) - YW'(r_h[0]);
            d2   = YW'(r_h[2]) - YW'(r_h[0]);
            w2   = signed'(10'(fz));
        end
        w1 = signed'(10'(fx));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_mul) begin
            r_p1   <= PRW'(d1) * PRW'(w1);
            r_p2   <= PRW'(d2) * PRW'(w2);
            r_base <= base;
        end
    end

    assign acc = (ACW'(r_base) <<< 8) + ACW'(r_p1) + ACW'(r_p2) + ACW'(128);
    assign rnd = acc >>> 8;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_sum) begin
            if (rnd > ACW'(H_MAX)) begin
                r_res_h <= HW'(H_MAX);
            end else if (rnd < ACW'(H_MIN)) begin
                r_res_h <= HW'(H_MIN);
            end else begin
                r_res_h <= rnd[HW-1:0];
            end
        end
    end

    // brush: read, square, compare and write back, one vertex per cycle
    assign dx = signed'(DW'({r_c1, 8'h00})) - signed'(DW'(r_xp));
    assign dz = signed'(DW'({r_r1, 8'h00})) - signed'(DW'(r_zp));
    assign dy = YW'(signed'(r_rdata)) - YW'(r_yp);

    assign dist2 = SQW'(r_dx2) + SQW'(r_dz2) + SQW'(r_dy2);
    assign sel   = dist2 < SQW'(r_r2);
    assign hsum  = YW'(r_h2) + YW'(r_val);
    assign hnew  = (hsum > YW'(H_MAX)) ? HW'(H_MAX) :
                   (hsum < YW'(H_MIN)) ? HW'(H_MIN) : hsum[HW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_br     <= '0;
            r_bc     <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.capture) begin
            r_issued <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_br     <= '0;
            r_bc     <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.b_run) begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (issue) begin
                if (r_bc == wm1[CW-1:0]) begin
                    r_bc <= '0;
                    if (r_br == dm1[CW-1:0]) begin
                        r_issued <= 1'b1;
                    end else begin
                        r_br <= r_br + CW'(1);
                    end
                end else begin
                    r_bc <= r_bc + CW'(1);
                end
            end
            if (r_v2 && sel) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.b_run) begin
            r_c1  <= r_bc;
            r_r1  <= r_br;
            r_dx2 <= dx * dx;
            r_dz2 <= dz * dz;
            r_dy2 <= dy * dy;
            r_h2  <= r_rdata;
            r_a2  <= {r_r1, r_c1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_height        <= (r_mode == MODE_QUERY) ? r_res_h : '0;
            o_changed_count <= (r_mode == MODE_BRUSH) ? r_cnt : '0;
        end
    end

    assign o_status.clr_last  = i_cmd.clr_step && (r_clr == '1);
    assign o_status.q_rd_last = (r_qk == 3'd4);
    assign o_status.b_done    = r_issued && !r_v1 && !r_v2;

endmodule

`default_nettype wire

### rtl/heightfield_sample_and_brush.sv
// channel   direction  handshake                    payload
// in        to block   i_in_valid / o_in_stall      i_mode .. i_radius
// out       from block o_out_valid / i_out_stall    o_height, o_changed_count
// config    to block   APB psel/penable/pwrite      paddr, pwdata, prdata
//
// A query makes four reads through the single read port of the height memory,
// then multiplies, then rounds. The brush sweep reads and writes back one
// vertex per cycle.
// After reset a clearing pass zeroes all 4**clog2(MAX_SIDE) words of the
// memory (65536 at the default); no request is taken until it ends.
// A finished result waits in the output register; a stalled result holds
// the next request in its done state.
`default_nettype none

module heightfield_sample_and_brush #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [7:0]                    i_vertex_col,
    input  wire logic [7:0]                    i_vertex_row,
    input  wire logic [hsb_pkg::POSW-1:0]      i_x_pos,
    input  wire logic [hsb_pkg::POSW-1:0]      i_z_pos,
    input  wire logic signed [hsb_pkg::HW-1:0] i_y_pos,
    input  wire logic signed [hsb_pkg::HW-1:0] i_value,
    input  wire logic [hsb_pkg::RADW-1:0]      i_radius,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [hsb_pkg::HW-1:0]      o_height,
    output logic [hsb_pkg::CNTW-1:0]           o_changed_count
);
    import hsb_pkg::*;

    logic [SIZEW-1:0] r_grid_width, r_grid_depth;
    t_cmd             cmd;
    t_status          status;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= SIZE_RESET;
            r_grid_depth <= SIZE_RESET;
        end else if (wr) begin
            if (paddr[2] == REG_GRID_WIDTH) begin
                r_grid_width <= pwdata[SIZEW-1:0];
            end else begin
                r_grid_depth <= pwdata[SIZEW-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GRID_DEPTH) ? 32'(r_grid_depth) : 32'(r_grid_width);

    hsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_mode),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    hsb_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_grid_width    (r_grid_width),
        .i_grid_depth    (r_grid_depth),
        .i_mode          (i_mode),
        .i_vertex_col    (i_vertex_col),
        .i_vertex_row    (i_vertex_row),
        .i_x_pos         (i_x_pos),
        .i_z_pos         (i_z_pos),
        .i_y_pos         (i_y_pos),
        .i_value         (i_value),
        .i_radius        (i_radius),
        .o_status        (status),
        .o_height        (o_height),
        .o_changed_count (o_changed_count)
    );

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while another is in progress");

    // the clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request port open right after reset");

    // a brush count and a query height never appear together
    a_fields_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_changed_count != '0)) |-> (o_height == '0))
        else $error("height and count both nonzero");

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;
    import hsb_pkg::*;

    localparam int  CYCLE_LIMIT  = 4000000;
    localparam int  ITEMS_PLAN   = 1320;
    localparam int  SIDE         = 256;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  HOLD_AT      = 500;
    localparam int  DRAIN_CYCLES = 16;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]           mode;
        logic [7:0]           col;
        logic [7:0]           row;
        logic [POSW-1:0]      x;
        logic [POSW-1:0]      z;
        logic signed [HW-1:0] y;
        logic signed [HW-1:0] val;
        logic [RADW-1:0]      rad;
    } t_req;

    typedef struct {
        logic signed [HW-1:0] height;
        logic [CNTW-1:0]      count;
    } t_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           in_mode = '0;
    logic [7:0]           in_col = '0;
    logic [7:0]           in_row = '0;
    logic [POSW-1:0]      in_x = '0;
    logic [POSW-1:0]      in_z = '0;
    logic signed [HW-1:0] in_y = '0;
    logic signed [HW-1:0] in_val = '0;
    logic [RADW-1:0]      in_rad = '0;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    logic signed [HW-1:0] o_height;
    logic [CNTW-1:0]      o_changed_count;

    heightfield_sample_and_brush uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_mode(in_mode), .i_vertex_col(in_col), .i_vertex_row(in_row),
        .i_x_pos(in_x), .i_z_pos(in_z), .i_y_pos(in_y), .i_value(in_val),
        .i_radius(in_rad),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_height(o_height), .o_changed_count(o_changed_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the block state
    logic signed [HW-1:0] height_map [0:SIDE*SIDE-1];
    logic [SIZEW-1:0]     cfg_w = SIZE_RESET;
    logic [SIZEW-1:0]     cfg_d = SIZE_RESET;

    t_req pending_req[$];
    t_res expected_res[$];
    int   sent_cnt = 0;
    int   recv_cnt = 0;
    int   mismatches = 0;
    int   cycles = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    function automatic int eff_side(logic [SIZEW-1:0] r);
        if (r < 2) return 2;
        if (r > SIDE) return SIDE;
        return int'(r);
    endfunction

    function automatic logic signed [HW-1:0] sat_h(longint v);
        if (v > H_MAX) return H_MAX;
        if (v < H_MIN) return H_MIN;
        return v[HW-1:0];
    endfunction

    function automatic logic signed [HW-1:0] surface_height(logic [POSW-1:0] xp,
                                                            logic [POSW-1:0] zp);
        int w, d, xc, zc, c, r;
        longint fx, fz, h00, h10, h01, h11, acc;
        w = eff_side(cfg_w);
        d = eff_side(cfg_d);
        xc = (int'(xp) > (w - 1) * 256) ? (w - 1) * 256 : int'(xp);
        zc = (int'(zp) > (d - 1) * 256) ? (d - 1) * 256 : int'(zp);
        c = xc >> 8;
        r = zc >> 8;
        if (c > w - 2) c = w - 2;
        if (r > d - 2) r = d - 2;
        fx = xc - c * 256;
        fz = zc - r * 256;
        h00 = height_map[r * SIDE + c];
        h10 = height_map[r * SIDE + c + 1];
        h01 = height_map[(r + 1) * SIDE + c];
        h11 = height_map[(r + 1) * SIDE + c + 1];
        if (fx > 256 - fz)
            acc = h01 * 256 + fx * (h11 - h01) + (256 - fz) * (h10 - h11);
        else
            acc = h00 * 256 + fx * (h10 - h00) + fz * (h01 - h00);
        return sat_h((acc + 128) >>> 8);
    endfunction

    function automatic int raise_brush(t_req q);
        int w, d, n;
        longint r2, dx, dz, dy, h;
        w = eff_side(cfg_w);
        d = eff_side(cfg_d);
        n = 0;
        r2 = longint'(q.rad) * longint'(q.rad);
        for (int r = 0; r < d; r++) begin
            for (int c = 0; c < w; c++) begin
                h = height_map[r * SIDE + c];
                dx = longint'(c) * 256 - longint'(q.x);
                dz = longint'(r) * 256 - longint'(q.z);
                dy = h - longint'(q.y);
                if (dx * dx + dz * dz + dy * dy < r2) begin
                    height_map[r * SIDE + c] = sat_h(h + longint'(q.val));
                    n++;
                end
            end
        end
        return n;
    endfunction

    function automatic t_res predict_result(t_req q);
        t_res e;
        e.height = '0;
        e.count = '0;
        case (q.mode)
            MODE_LOAD: begin
                if (q.col < eff_side(cfg_w) && q.row < eff_side(cfg_d))
                    height_map[int'(q.row) * SIDE + int'(q.col)] = q.val;
            end
            MODE_QUERY: e.height = surface_height(q.x, q.z);
            MODE_BRUSH: e.count = CNTW'(raise_brush(q));
            default: ;
        endcase
        return e;
    endfunction

    // idling profile moves with progress through the stimulus
    function automatic int tx_idle_pct();
        if (sent_cnt < ITEMS_PLAN / 3) return 9;
        if (sent_cnt < 2 * ITEMS_PLAN / 3) return 46;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (recv_cnt < ITEMS_PLAN / 3) return 46;
        if (recv_cnt < 2 * ITEMS_PLAN / 3) return 9;
        return 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_req q;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                q.mode = in_mode; q.col = in_col; q.row = in_row; q.x = in_x;
                q.z = in_z; q.y = in_y; q.val = in_val; q.rad = in_rad;
                expected_res.push_back(predict_result(q));
                sent_cnt++;
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_req.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
                    q = pending_req.pop_front();
                    in_mode <= q.mode; in_col <= q.col; in_row <= q.row; in_x <= q.x;
                    in_z <= q.z; in_y <= q.y; in_val <= q.val; in_rad <= q.rad;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // one long hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && recv_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                recv_cnt++;
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result height=%0d count=%0d",
                                 o_height, o_changed_count);
                end else begin
                    e = expected_res.pop_front();
                    if (o_height !== e.height || o_changed_count !== e.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch #%0d: height exp %0d got %0d,",
                                      " count exp %0d got %0d"},
                                     recv_cnt, e.height, o_height, e.count,
                                     o_changed_count);
                    end
                end
            end
            if (hold_left > 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("status: fail");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_grid(int w, int d);
        reg_write({REG_GRID_WIDTH, 2'b00}, w);
        reg_write({REG_GRID_DEPTH, 2'b00}, d);
        cfg_w = SIZEW'(w);
        cfg_d = SIZEW'(d);
    endtask

    task automatic drain();
        while (pending_req.size() > 0 || in_valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_req mk(logic [1:0] m, int col, int row, int x, int z,
                                int y, int val, int rad);
        t_req q;
        q.mode = m; q.col = 8'(col); q.row = 8'(row); q.x = POSW'(x); q.z = POSW'(z);
        q.y = HW'(y); q.val = HW'(val); q.rad = RADW'(rad);
        return q;
    endfunction

    function automatic t_req rand_req(int brush_pct);
        t_req q;
        int w, d, p;
        w = eff_side(cfg_w);
        d = eff_side(cfg_d);
        q.col = 8'($urandom); q.row = 8'($urandom);
        q.x = POSW'($urandom); q.z = POSW'($urandom);
        q.y = HW'($urandom); q.val = HW'($urandom); q.rad = RADW'($urandom);
        p = $urandom_range(0, 99);
        if (p < brush_pct) q.mode = MODE_BRUSH;
        else if (p < brush_pct + (100 - brush_pct) / 2) q.mode = MODE_LOAD;
        else if (p < 97) q.mode = MODE_QUERY;
        else q.mode = MODE_UNUSED;
        // mostly in-grid, moderate values; the rest stays full range
        if ($urandom_range(0, 7) != 0) begin
            q.col = 8'($urandom_range(0, w - 1));
            q.row = 8'($urandom_range(0, d - 1));
            q.x = POSW'($urandom_range(0, (w - 1) * 256 + 128));
            q.z = POSW'($urandom_range(0, (d - 1) * 256 + 128));
            q.y = HW'(int'($urandom_range(0, 4000)) - 2000);
            q.val = ($urandom_range(0, 15) == 0) ? HW'($urandom_range(0, 1) ? H_MAX : H_MIN)
                                                 : HW'(int'($urandom_range(0, 4000)) - 2000);
            q.rad = RADW'($urandom_range(0, 3 * 256));
        end
        return q;
    endfunction

    task automatic run_random(int n, int brush_pct);
        repeat (n) pending_req.push_back(rand_req(brush_pct));
        drain();
    endtask

    initial begin
        for (int i = 0; i < SIDE * SIDE; i++) height_map[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, default 64x64 grid
        pending_req.push_back(mk(MODE_LOAD, 0, 0, 0, 0, 0, H_MAX, 0));
        pending_req.push_back(mk(MODE_LOAD, 1, 0, 0, 0, 0, H_MIN, 0));
        pending_req.push_back(mk(MODE_LOAD, 0, 1, 0, 0, 0, 1000, 0));
        pending_req.push_back(mk(MODE_LOAD, 63, 63, 0, 0, 0, -1, 0));
        pending_req.push_back(mk(MODE_LOAD, 255, 255, 0, 0, 0, 777, 0));
        pending_req.push_back(mk(MODE_LOAD, 64, 3, 0, 0, 0, 555, 0));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 10, 20, 0, 0, 0));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 200, 200, 0, 0, 0));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 128, 128, 0, 0, 0));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 65535, 65535, 0, 0, 0));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 63 * 256, 100, 0, 0, 0));
        pending_req.push_back(mk(MODE_UNUSED, 255, 255, 65535, 65535, -1, -1, 131071));
        pending_req.push_back(mk(MODE_BRUSH, 0, 0, 0, 0, 0, 500, 0));
        pending_req.push_back(mk(MODE_BRUSH, 0, 0, 0, 0, 0, H_MAX, 131071));
        pending_req.push_back(mk(MODE_BRUSH, 0, 0, 300, 300, 0, 0, 600));
        pending_req.push_back(mk(MODE_BRUSH, 0, 0, 65535, 65535, H_MIN, H_MIN, 131071));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 64, 32, 0, 0, 0));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 255, 1, 0, 0, 0));
        drain();
        run_random(150, 5);

        set_grid(2, 2);
        run_random(200, 30);
        set_grid(256, 256);
        pending_req.push_back(mk(MODE_LOAD, 255, 255, 0, 0, 0, 4242, 0));
        pending_req.push_back(mk(MODE_QUERY, 0, 0, 65535, 65535, 0, 0, 0));
        pending_req.push_back(mk(MODE_BRUSH, 0, 0, 65280, 65280, 4000, 9, 1000));
        run_random(40, 0);
        set_grid(0, 1);
        run_random(100, 30);
        set_grid(511, 3);
        run_random(200, 15);
        set_grid(5, 200);
        run_random(200, 15);
        for (int k = 0; k < 6; k++) begin
            set_grid(int'($urandom_range(2, 12)), int'($urandom_range(2, 12)));
            run_random(50, 25);
        end
        set_grid(300, 2);
        run_random(100, 15);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/hsb_pkg.sv
rtl/hsb_ctrl.sv
rtl/hsb_dp.sv
rtl/heightfield_sample_and_brush.sv
sim/tb.sv
